[hdl/pfa_pkg.sv]
// Shared types and constants for the page frame allocator with FIFO eviction.
// Used by pfa_front, pfa_back and page_frame_allocator_fifo_evict; no dependencies.
package pfa_pkg;

  localparam int RAM_NFRAMES = 32;
  localparam int SWAP_FRAMES = 128;
  localparam int MAX_PAGES   = 64;
  localparam int QDEPTH      = 128;
  localparam int RAM_AW      = 5;
  localparam int RAM_CW      = 6;
  localparam int SWAP_AW     = 7;
  localparam int SWAP_CW     = 8;
  localparam int Q_AW        = 7;
  localparam int Q_CW        = 8;
  localparam int PID_W       = 8;
  localparam int TENTH_MUL   = 205;
  localparam int TENTH_SHIFT = 11;
  localparam int CMD_DEPTH   = 2;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_FAULT    = 2'd1,
    OP_REL_RAM  = 2'd2,
    OP_REL_SWAP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_VICTIM = 2'd1,
    ST_NO_SWAP   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    B_IDLE,
    R_EXEC,
    L_INIT,
    L_RAM,
    L_SWRD,
    L_SWEMIT,
    F_START,
    F_SCAN,
    F_CHECK,
    F_SWAP,
    F_FINISH
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [PID_W-1:0] pid;
    logic [5:0]       page;
    logic [6:0]       tp;
    logic [2:0]       tenth;
    logic [6:0]       fidx;
    logic             holds;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

[hdl/pfa_front.sv]
// Command front end: accepts commands, saturates the load size and
// precomputes a tenth of it, and holds them in a two-entry queue. Uses pfa_pkg.
module pfa_front
  import pfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode,
  input  logic [PID_W-1:0] pid,
  input  logic [5:0]       page_no,
  input  logic [6:0]       total_pages,
  input  logic [6:0]       frame_index,
  input  logic             holds_swap_frame,
  output cmd_chan_t        chan,
  input  logic             take
);

  logic [1:0]  count;
  cmd_t        slot0;
  cmd_t        slot1;
  cmd_t        incoming;
  logic        push;
  logic [6:0]  tp_sat;
  logic [14:0] tenth_prod;

  assign busy = (count == 2'(CMD_DEPTH));
  assign push = start && !busy;

  always_comb begin
    tp_sat = (total_pages > 7'(MAX_PAGES)) ? 7'(MAX_PAGES) : total_pages;
    tenth_prod = 15'(tp_sat) * 15'(TENTH_MUL);
    incoming.op    = op_t'(opcode);
    incoming.pid   = pid;
    incoming.page  = page_no;
    incoming.tp    = tp_sat;
    incoming.tenth = 3'(tenth_prod >> TENTH_SHIFT);
    incoming.fidx  = frame_index;
    incoming.holds = holds_swap_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + 2'(push) - 2'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= incoming;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= incoming;
      end else begin
        slot1 <= incoming;
      end
    end
  end

  assign chan.valid = (count != 2'd0);
  assign chan.cmd   = slot0;

endmodule

[hdl/pfa_back.sv]
// Execution engine: free stacks, owner table, eviction queue and result register.
// Uses pfa_pkg; fed by pfa_front through a cmd_chan_t.
module pfa_back
  import pfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_chan_t          chan,
  output logic               take,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic [5:0]         page_out,
  output logic               in_ram,
  output logic [6:0]         frame_out,
  output logic               evicted,
  output logic [PID_W-1:0]   victim_pid,
  output logic [5:0]         victim_page,
  output logic [6:0]         victim_swap_frame,
  output logic [5:0]         ram_in_use,
  output logic [7:0]         swap_in_use,
  output logic               last
);

  back_state_t state, state_next;
  cmd_t        cur;

  logic [RAM_AW-1:0]  ram_free_stack [RAM_NFRAMES];
  logic [RAM_CW-1:0]  ram_free_count;
  logic [RAM_NFRAMES-1:0] ram_occupied;
  logic [PID_W-1:0]   ram_owner [RAM_NFRAMES];
  logic [5:0]         ram_owner_page [RAM_NFRAMES];
  logic [RAM_CW-1:0]  ram_used, ram_used_next;

  logic [SWAP_AW-1:0] swap_mem [SWAP_FRAMES];
  logic [SWAP_FRAMES-1:0] swap_valid;
  logic [SWAP_FRAMES-1:0] swap_occ;
  logic [SWAP_CW-1:0] swap_free_count;
  logic [SWAP_CW-1:0] swap_used, swap_used_next;
  logic [SWAP_AW-1:0] swap_rd_addr, swap_rd_data, swap_rd_value;
  logic               swap_rd_valid;

  logic [RAM_AW-1:0]  q_mem [QDEPTH];
  logic [Q_AW-1:0]    q_head;
  logic [Q_CW-1:0]    q_count;
  logic [RAM_AW-1:0]  q_rd_data;

  logic [6:0]         pg;
  logic [6:0]         ram_left;
  logic [RAM_AW-1:0]  frame;
  logic               from_free;
  logic               ev;
  logic [SWAP_AW-1:0] sw;
  logic [PID_W-1:0]   vpid;
  logic [5:0]         vpg;

  logic [RAM_CW-1:0]  rfc_m1;
  logic [RAM_AW-1:0]  ram_top;
  logic [SWAP_CW-1:0] sfc_m1;
  logic [6:0]         for_ram_a, for_ram_b, for_ram, for_swap;
  logic               load_fail;
  logic               pg_last;

  logic               emit;
  status_t            e_status;
  logic [5:0]         e_page;
  logic               e_inram;
  logic [6:0]         e_frame;
  logic               e_ev;
  logic               push_en;
  logic [RAM_AW-1:0]  push_val;
  logic               ram_pop_en, swap_rd_en, swap_pop_en, swap_rel_en, ram_rel_en, scan_en;
  logic               own_wr;
  logic [RAM_AW-1:0]  own_frame;
  logic [PID_W-1:0]   own_pid;
  logic [5:0]         own_page;

  assign rfc_m1  = ram_free_count - RAM_CW'(1);
  assign ram_top = ram_free_stack[rfc_m1[RAM_AW-1:0]];
  assign sfc_m1  = swap_free_count - SWAP_CW'(1);
  assign swap_rd_value = swap_rd_valid ? swap_rd_data
                                       : SWAP_AW'(SWAP_FRAMES - 1) - swap_rd_addr;
  assign pg_last = ((pg + 7'd1) == cur.tp);

  always_comb begin
    for_ram_a = (cur.tenth == 3'd0) ? 7'd1 : 7'(cur.tenth);
    for_ram_b = (for_ram_a > cur.tp) ? cur.tp : for_ram_a;
    for_ram   = (for_ram_b > 7'(ram_free_count)) ? 7'(ram_free_count) : for_ram_b;
    for_swap  = cur.tp - for_ram;
    load_fail = (swap_free_count < 8'(for_swap));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    take           = 1'b0;
    emit           = 1'b0;
    e_status       = ST_OK;
    e_page         = '0;
    e_inram        = 1'b0;
    e_frame        = '0;
    e_ev           = 1'b0;
    push_en        = 1'b0;
    push_val       = frame;
    ram_pop_en     = 1'b0;
    swap_rd_en     = 1'b0;
    swap_pop_en    = 1'b0;
    swap_rel_en    = 1'b0;
    ram_rel_en     = 1'b0;
    scan_en        = 1'b0;
    own_wr         = 1'b0;
    own_frame      = frame;
    own_pid        = cur.pid;
    own_page       = cur.page;
    ram_used_next  = ram_used;
    swap_used_next = swap_used;
    unique case (state)
      B_IDLE: begin
        if (chan.valid) begin
          take = 1'b1;
          unique case (chan.cmd.op)
            OP_LOAD:  state_next = L_INIT;
            OP_FAULT: state_next = F_START;
            default:  state_next = R_EXEC;
          endcase
        end
      end
      R_EXEC: begin
        if (cur.op == OP_REL_RAM) begin
          if (cur.fidx < 7'(RAM_NFRAMES) && ram_occupied[cur.fidx[RAM_AW-1:0]]
              && ram_free_count < RAM_CW'(RAM_NFRAMES)) begin
            ram_rel_en    = 1'b1;
            ram_used_next = ram_used - RAM_CW'(1);
          end
        end else begin
          if (swap_occ[cur.fidx] && swap_free_count < SWAP_CW'(SWAP_FRAMES)) begin
            swap_rel_en    = 1'b1;
            swap_used_next = swap_used - SWAP_CW'(1);
          end
        end
        emit       = 1'b1;
        state_next = B_IDLE;
      end
      L_INIT: begin
        if (load_fail) begin
          emit       = 1'b1;
          e_status   = ST_NO_SWAP;
          state_next = B_IDLE;
        end else if (cur.tp == 7'd0) begin
          emit       = 1'b1;
          state_next = B_IDLE;
        end else begin
          ram_used_next  = ram_used + for_ram[RAM_CW-1:0];
          swap_used_next = swap_used + SWAP_CW'(for_swap);
          state_next     = (for_ram != 7'd0) ? L_RAM : L_SWRD;
        end
      end
      L_RAM: begin
        ram_pop_en = 1'b1;
        own_wr     = 1'b1;
        own_frame  = ram_top;
        own_page   = pg[5:0];
        push_en    = 1'b1;
        push_val   = ram_top;
        emit       = 1'b1;
        e_page     = pg[5:0];
        e_inram    = 1'b1;
        e_frame    = 7'(ram_top);
        if (pg_last) begin
          state_next = B_IDLE;
        end else if (ram_left == 7'd1) begin
          state_next = L_SWRD;
        end
      end
      L_SWRD: begin
        swap_rd_en = 1'b1;
        state_next = L_SWEMIT;
      end
      L_SWEMIT: begin
        swap_pop_en = 1'b1;
        emit        = 1'b1;
        e_page      = pg[5:0];
        e_frame     = swap_rd_value;
        state_next  = pg_last ? B_IDLE : L_SWRD;
      end
      F_START: begin
        if (ram_free_count != '0) begin
          ram_pop_en = 1'b1;
          state_next = F_FINISH;
        end else begin
          state_next = F_SCAN;
        end
      end
      F_SCAN: begin
        if (q_count == '0) begin
          emit       = 1'b1;
          e_status   = ST_NO_VICTIM;
          e_page     = cur.page;
          state_next = B_IDLE;
        end else begin
          scan_en    = 1'b1;
          state_next = F_CHECK;
        end
      end
      F_CHECK: begin
        if (ram_occupied[q_rd_data]) begin
          if (swap_free_count == '0) begin
            push_en    = 1'b1;
            push_val   = q_rd_data;
            emit       = 1'b1;
            e_status   = ST_NO_SWAP;
            e_page     = cur.page;
            state_next = B_IDLE;
          end else begin
            swap_rd_en = 1'b1;
            state_next = F_SWAP;
          end
        end else begin
          state_next = F_SCAN;
        end
      end
      F_SWAP: begin
        swap_pop_en    = 1'b1;
        swap_used_next = swap_used + SWAP_CW'(1);
        state_next     = F_FINISH;
      end
      F_FINISH: begin
        if (cur.holds && swap_occ[cur.fidx] && swap_free_count < SWAP_CW'(SWAP_FRAMES)) begin
          swap_rel_en    = 1'b1;
          swap_used_next = swap_used - SWAP_CW'(1);
        end
        if (from_free) begin
          ram_used_next = ram_used + RAM_CW'(1);
        end
        own_wr     = 1'b1;
        push_en    = 1'b1;
        emit       = 1'b1;
        e_page     = cur.page;
        e_inram    = 1'b1;
        e_frame    = 7'(frame);
        e_ev       = ev;
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control registers: counts, occupancy, pointers and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RAM_NFRAMES; i++) begin
        ram_free_stack[i] <= RAM_AW'(RAM_NFRAMES - 1 - i);
      end
      ram_free_count  <= RAM_CW'(RAM_NFRAMES);
      ram_occupied    <= '0;
      ram_used        <= '0;
      swap_valid      <= '0;
      swap_occ        <= '0;
      swap_free_count <= SWAP_CW'(SWAP_FRAMES);
      swap_used       <= '0;
      q_head          <= '0;
      q_count         <= '0;
      result_valid    <= 1'b0;
    end else begin
      ram_used     <= ram_used_next;
      swap_used    <= swap_used_next;
      result_valid <= emit;
      if (ram_pop_en) begin
        ram_free_count <= rfc_m1;
      end
      if (ram_rel_en) begin
        ram_free_stack[ram_free_count[RAM_AW-1:0]] <= cur.fidx[RAM_AW-1:0];
        ram_free_count <= ram_free_count + RAM_CW'(1);
        ram_occupied[cur.fidx[RAM_AW-1:0]] <= 1'b0;
      end
      if (own_wr) begin
        ram_occupied[own_frame] <= 1'b1;
      end
      if (swap_pop_en) begin
        swap_free_count <= sfc_m1;
        swap_occ[swap_rd_value] <= 1'b1;
      end
      if (swap_rel_en) begin
        swap_valid[swap_free_count[SWAP_AW-1:0]] <= 1'b1;
        swap_free_count <= swap_free_count + SWAP_CW'(1);
        swap_occ[cur.fidx] <= 1'b0;
      end
      if (push_en) begin
        if (q_count == Q_CW'(QDEPTH)) begin
          q_head <= q_head + Q_AW'(1);
        end else begin
          q_count <= q_count + Q_CW'(1);
        end
      end
      if (scan_en) begin
        q_head  <= q_head + Q_AW'(1);
        q_count <= q_count - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (own_wr) begin
      ram_owner[own_frame]      <= own_pid;
      ram_owner_page[own_frame] <= own_page;
    end
  end

  always_ff @(posedge clk) begin
    if (swap_rel_en) begin
      swap_mem[swap_free_count[SWAP_AW-1:0]] <= cur.fidx;
    end
    if (swap_rd_en) begin
      swap_rd_addr  <= sfc_m1[SWAP_AW-1:0];
      swap_rd_data  <= swap_mem[sfc_m1[SWAP_AW-1:0]];
      swap_rd_valid <= swap_valid[sfc_m1[SWAP_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      if (q_count == Q_CW'(QDEPTH)) begin
        q_mem[q_head] <= push_val;
      end else begin
        q_mem[q_head + q_count[Q_AW-1:0]] <= push_val;
      end
    end
    if (scan_en) begin
      q_rd_data <= q_mem[q_head];
    end
  end

  // Item-level working registers and the result register.
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= chan.cmd;
    end
    unique case (state)
      L_INIT: begin
        pg       <= '0;
        ram_left <= for_ram;
      end
      L_RAM: begin
        pg       <= pg + 7'd1;
        ram_left <= ram_left - 7'd1;
      end
      L_SWEMIT: pg <= pg + 7'd1;
      F_START: begin
        frame     <= ram_top;
        from_free <= (ram_free_count != '0);
        ev        <= 1'b0;
        sw        <= '0;
        vpid      <= '0;
        vpg       <= '0;
      end
      F_CHECK: frame <= q_rd_data;
      F_SWAP: begin
        sw   <= swap_rd_value;
        ev   <= 1'b1;
        vpid <= ram_owner[frame];
        vpg  <= ram_owner_page[frame];
      end
      default: begin
      end
    endcase
    if (emit) begin
      status            <= e_status;
      page_out          <= e_page;
      in_ram            <= e_inram;
      frame_out         <= e_frame;
      evicted           <= e_ev;
      victim_pid        <= e_ev ? vpid : '0;
      victim_page       <= e_ev ? vpg : '0;
      victim_swap_frame <= e_ev ? sw : '0;
      ram_in_use        <= ram_used_next;
      swap_in_use       <= swap_used_next;
      last              <= (state != L_RAM && state != L_SWEMIT) || pg_last;
    end
  end

  a_ram_balance: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> (ram_used + ram_free_count == RAM_CW'(RAM_NFRAMES)))
    else $error("RAM used and free counts disagree");

  a_swap_balance: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> (swap_used + swap_free_count == SWAP_CW'(SWAP_FRAMES)))
    else $error("swap used and free counts disagree");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= Q_CW'(QDEPTH))
    else $error("eviction queue overfilled");

  a_take_quiet: assert property (@(posedge clk) disable iff (rst)
    take |=> !result_valid)
    else $error("result strobe right after a command transfer");

endmodule

[hdl/page_frame_allocator_fifo_evict.sv]
// Top level of the page frame allocator with FIFO eviction.
// Instantiates pfa_front and pfa_back; uses pfa_pkg.
//
// Usage: a command transfer happens on a rising edge with start high and busy
// low. opcode selects load, page fault, RAM frame release or swap frame
// release. The front end queues up to two commands, so busy rises only when
// both slots are full. Each result appears for one cycle with result_valid
// high; last marks the final result of a command. The receiver cannot stall.
// Each result is registered from the back-end state that forms it. A release
// is handled in a single back-end state. A load first checks the swap space,
// then emits one result per RAM page, then for each swap page reads the swap
// free stack and emits the result. A fault takes a free frame if there is one;
// otherwise it scans the eviction queue until it finds an occupied frame or
// the queue is empty, then reads the swap stack; both reads are registered.
// The back end takes a new command only after it has finished the last one.
// Reset: synchronous, active high. Both free stacks come up full, so frame 0
// is handed out first, and the queue and the used counts are empty. No clearing
// pass is needed; the swap stack uses per-entry valid bits.
module page_frame_allocator_fifo_evict
  import pfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode,
  input  logic [PID_W-1:0] pid,
  input  logic [5:0]       page_no,
  input  logic [6:0]       total_pages,
  input  logic [6:0]       frame_index,
  input  logic             holds_swap_frame,
  output logic             result_valid,
  output logic [1:0]       status,
  output logic [5:0]       page_out,
  output logic             in_ram,
  output logic [6:0]       frame_out,
  output logic             evicted,
  output logic [PID_W-1:0] victim_pid,
  output logic [5:0]       victim_page,
  output logic [6:0]       victim_swap_frame,
  output logic [5:0]       ram_in_use,
  output logic [7:0]       swap_in_use,
  output logic             last
);

  cmd_chan_t chan;
  logic      take;

  pfa_front u_front (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .opcode           (opcode),
    .pid              (pid),
    .page_no          (page_no),
    .total_pages      (total_pages),
    .frame_index      (frame_index),
    .holds_swap_frame (holds_swap_frame),
    .chan             (chan),
    .take             (take)
  );

  pfa_back u_back (
    .clk               (clk),
    .rst               (rst),
    .chan              (chan),
    .take              (take),
    .result_valid      (result_valid),
    .status            (status),
    .page_out          (page_out),
    .in_ram            (in_ram),
    .frame_out         (frame_out),
    .evicted           (evicted),
    .victim_pid        (victim_pid),
    .victim_page       (victim_page),
    .victim_swap_frame (victim_swap_frame),
    .ram_in_use        (ram_in_use),
    .swap_in_use       (swap_in_use),
    .last              (last)
  );

endmodule
